[sv/sorted_linked_list_pool_engine_defines.svh]
// Assertion macros for the sorted linked list pool engine.
`ifndef SORTED_LINKED_LIST_POOL_ENGINE_DEFINES_SVH
`define SORTED_LINKED_LIST_POOL_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge and disabled during reset.
`define SLPE_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and disabled during reset.
`define SLPE_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`else

`define SLPE_ASSERT_IMP(lbl, ant, con, msg)
`define SLPE_ASSERT_NXT(lbl, ant, con, msg)

`endif

`endif

[sv/slpe_pkg.sv]
// Package with sizes, command codes, types and helpers of the pool engine.
package slpe_pkg;

  localparam int PoolEntries = 64;
  localparam int NumLists    = 4;

  localparam int IdxW     = $clog2(PoolEntries);
  localparam int LinkW    = $clog2(PoolEntries + 1);
  localparam int ListW    = (NumLists > 1) ? $clog2(NumLists) : 1;
  localparam int CmdW     = 3;
  localparam int KeyW     = 16;
  localparam int ListSelW = 2;

  // The null link is the first value past the last entry.
  localparam logic [LinkW-1:0] LinkNil = LinkW'(PoolEntries);

  localparam logic [CmdW-1:0] CmdAlloc  = CmdW'(0);
  localparam logic [CmdW-1:0] CmdFree   = CmdW'(1);
  localparam logic [CmdW-1:0] CmdInsert = CmdW'(2);
  localparam logic [CmdW-1:0] CmdRemove = CmdW'(3);
  localparam logic [CmdW-1:0] CmdMove   = CmdW'(4);

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
  } row_t;

  localparam int RowW = $bits(row_t);

  // One pending read-modify-write of a row.
  typedef struct packed {
    logic [IdxW-1:0]  addr;
    logic             set_key;
    logic             set_nxt;
    logic             set_prv;
    logic [KeyW-1:0]  key;
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
  } rmw_op_t;

  function automatic logic is_entry(logic [LinkW-1:0] l);
    return l < LinkNil;
  endfunction

  function automatic logic [LinkW-1:0] to_link(logic [IdxW-1:0] i);
    return LinkW'(i);
  endfunction

  function automatic logic [IdxW-1:0] to_idx(logic [LinkW-1:0] l);
    return l[IdxW-1:0];
  endfunction

  // Row contents after reset: each entry links to the next, the last one to null.
  function automatic row_t reset_row(logic [IdxW-1:0] i);
    row_t r;
    r.key = '0;
    r.nxt = LinkW'(i) + LinkW'(1);
    r.prv = LinkNil;
    return r;
  endfunction

  function automatic rmw_op_t mk_op(logic [IdxW-1:0] addr, logic set_key, logic set_nxt,
                                    logic set_prv, logic [KeyW-1:0] key,
                                    logic [LinkW-1:0] nxt, logic [LinkW-1:0] prv);
    rmw_op_t op;
    op.addr    = addr;
    op.set_key = set_key;
    op.set_nxt = set_nxt;
    op.set_prv = set_prv;
    op.key     = key;
    op.nxt     = nxt;
    op.prv     = prv;
    return op;
  endfunction

endpackage

[sv/slpe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/sorted_linked_list_pool_engine.sv]
// Top level of the sorted linked list pool engine: command sequencer around one row memory.
//
// The engine keeps a pool of entries in one free list and several lists sorted by a 16-bit
// key, all held in a single row memory (key, next link, previous link per entry) with a
// registered read. A request is taken only while the sequencer is idle; its single
// result goes to an output register, so a new request may be taken while that result
// still waits to be collected. Every link update is a read of the row followed by a
// write of the merged row. Insert and move read one row for every entry passed while
// searching for the insertion point, one memory read per link. The search gives up after
// 64 links. A request whose result finds the output register still full waits in its
// last state until the register is collected. There is no clearing pass after reset: a
// valid bit per row makes a row that has never been written read back with its reset
// links, so the block takes requests at once.
// Allocating from an empty pool returns status one and index zero and changes nothing;
// unknown commands and out-of-range lists or entries return zeros and change nothing.
`include "sorted_linked_list_pool_engine_defines.svh"

module sorted_linked_list_pool_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slpe_pkg::CmdW-1:0]     command_i,
  input  logic [slpe_pkg::IdxW-1:0]     entry_index_i,
  input  logic [slpe_pkg::KeyW-1:0]     sort_key_i,
  input  logic [slpe_pkg::ListSelW-1:0] list_select_i,
  input  logic [slpe_pkg::ListSelW-1:0] dest_list_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slpe_pkg::IdxW-1:0]     allocated_index_o,
  output logic                          status_o
);

  // Sequencer states.
  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StDone  = 5'd1;
  localparam logic [4:0] StRmwWr = 5'd2;
  localparam logic [4:0] StAl0   = 5'd3;
  localparam logic [4:0] StAl1   = 5'd4;
  localparam logic [4:0] StAl2   = 5'd5;
  localparam logic [4:0] StFr0   = 5'd6;
  localparam logic [4:0] StFr1   = 5'd7;
  localparam logic [4:0] StIns0  = 5'd8;
  localparam logic [4:0] StUl0   = 5'd9;
  localparam logic [4:0] StUl1   = 5'd10;
  localparam logic [4:0] StUl1b  = 5'd11;
  localparam logic [4:0] StUl2   = 5'd12;
  localparam logic [4:0] StLk0   = 5'd13;
  localparam logic [4:0] StLk1   = 5'd14;
  localparam logic [4:0] StLk2   = 5'd15;
  localparam logic [4:0] StLk3   = 5'd16;
  localparam logic [4:0] StWalk  = 5'd17;
  localparam logic [4:0] StInsA  = 5'd18;
  localparam logic [4:0] StInsB  = 5'd19;
  localparam logic [4:0] StInsC  = 5'd20;

  // Control state.
  logic [4:0] state_q, state_d;
  logic [4:0] ret_q, ret_d;
  logic       out_valid_q, out_valid_d;
  logic [slpe_pkg::LinkW-1:0] fh_q, fh_d;
  logic [slpe_pkg::LinkW-1:0] head_q [slpe_pkg::NumLists];
  logic [slpe_pkg::PoolEntries-1:0] valid_q;
  logic rd_valid_q;

  // Working registers of the current request.
  slpe_pkg::rmw_op_t op_q, op_d;
  logic [slpe_pkg::IdxW-1:0]  e_q, e_d;
  logic [slpe_pkg::KeyW-1:0]  k_q, k_d;
  logic [slpe_pkg::ListW-1:0] lst_q, lst_d;
  logic [slpe_pkg::ListW-1:0] dst_q, dst_d;
  logic                       mv_q, mv_d;
  logic [slpe_pkg::LinkW-1:0] cur_q, cur_d;
  logic [slpe_pkg::LinkW-1:0] n_q, n_d;
  logic [slpe_pkg::LinkW-1:0] p_q, p_d;
  logic [slpe_pkg::LinkW-1:0] steps_q, steps_d;
  logic [slpe_pkg::IdxW-1:0]  res_idx_q, res_idx_d;
  logic                       res_st_q, res_st_d;
  logic [slpe_pkg::IdxW-1:0]  out_idx_q, out_idx_d;
  logic                       out_st_q, out_st_d;
  logic [slpe_pkg::IdxW-1:0]  rd_addr_q;

  // Memory port signals.
  logic                         ram_re, ram_we;
  logic [slpe_pkg::IdxW-1:0]    ram_raddr;
  logic [slpe_pkg::RowW-1:0]    ram_rdata;
  slpe_pkg::row_t               row_rd, row_wr;

  logic                       start_rmw;
  logic                       head_we;
  logic [slpe_pkg::LinkW-1:0] head_wdata;
  logic [slpe_pkg::LinkW-1:0] head_cur;
  logic                       idx_ok, src_ok, dst_ok, out_load;

  slpe_ram #(
    .Width(slpe_pkg::RowW),
    .Depth(slpe_pkg::PoolEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(op_q.addr),
    .wdata_i(row_wr),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A row that has never been written reads back with its reset contents.
  assign row_rd = rd_valid_q ? slpe_pkg::row_t'(ram_rdata) : slpe_pkg::reset_row(rd_addr_q);

  // The pending operation overwrites only the fields it names.
  always_comb begin
    row_wr = row_rd;
    if (op_q.set_key) begin
      row_wr.key = op_q.key;
    end
    if (op_q.set_nxt) begin
      row_wr.nxt = op_q.nxt;
    end
    if (op_q.set_prv) begin
      row_wr.prv = op_q.prv;
    end
  end

  assign head_cur = head_q[lst_q];
  assign idx_ok   = 32'(entry_index_i) < 32'(slpe_pkg::PoolEntries);
  assign src_ok   = 32'(list_select_i) < 32'(slpe_pkg::NumLists);
  assign dst_ok   = 32'(dest_list_i) < 32'(slpe_pkg::NumLists);

  assign in_ready_o        = (state_q == StIdle);
  assign out_valid_o       = out_valid_q;
  assign allocated_index_o = out_idx_q;
  assign status_o          = out_st_q;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    op_d       = op_q;
    start_rmw  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    fh_d       = fh_q;
    head_we    = 1'b0;
    head_wdata = slpe_pkg::LinkNil;
    e_d        = e_q;
    k_d        = k_q;
    lst_d      = lst_q;
    dst_d      = dst_q;
    mv_d       = mv_q;
    cur_d      = cur_q;
    n_d        = n_q;
    p_d        = p_q;
    steps_d    = steps_q;
    res_idx_d  = res_idx_q;
    res_st_d   = res_st_q;
    out_load   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          e_d       = entry_index_i;
          k_d       = sort_key_i;
          lst_d     = slpe_pkg::ListW'(list_select_i);
          dst_d     = slpe_pkg::ListW'(dest_list_i);
          mv_d      = 1'b0;
          res_idx_d = '0;
          res_st_d  = 1'b0;
          unique case (command_i)
            slpe_pkg::CmdAlloc:  state_d = StAl0;
            slpe_pkg::CmdFree:   state_d = idx_ok ? StFr0 : StDone;
            slpe_pkg::CmdInsert: state_d = (idx_ok && src_ok) ? StIns0 : StDone;
            slpe_pkg::CmdRemove: state_d = (idx_ok && src_ok) ? StUl0 : StDone;
            slpe_pkg::CmdMove: begin
              mv_d    = 1'b1;
              state_d = (idx_ok && src_ok && dst_ok) ? StUl0 : StDone;
            end
            default: state_d = StDone;
          endcase
        end
      end

      StRmwWr: begin
        ram_we  = 1'b1;
        state_d = ret_q;
      end

      // Allocate: pop the free head.
      StAl0: begin
        if (!slpe_pkg::is_entry(fh_q)) begin
          res_st_d = 1'b1;
          state_d  = StDone;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slpe_pkg::to_idx(fh_q);
          e_d       = slpe_pkg::to_idx(fh_q);
          res_idx_d = slpe_pkg::to_idx(fh_q);
          state_d   = StAl1;
        end
      end
      StAl1: begin
        fh_d = row_rd.nxt;
        if (slpe_pkg::is_entry(row_rd.nxt)) begin
          op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(row_rd.nxt), 1'b0, 1'b0, 1'b1, '0,
                                 slpe_pkg::LinkNil, slpe_pkg::LinkNil);
          ret_d     = StAl2;
          start_rmw = 1'b1;
        end else begin
          state_d = StAl2;
        end
      end
      StAl2: begin
        op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0,
                               slpe_pkg::LinkNil, slpe_pkg::LinkNil);
        ret_d     = StDone;
        start_rmw = 1'b1;
      end

      // Free: push the entry onto the free list.
      StFr0: begin
        if (slpe_pkg::is_entry(fh_q)) begin
          op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(fh_q), 1'b0, 1'b0, 1'b1, '0,
                                 slpe_pkg::LinkNil, slpe_pkg::to_link(e_q));
          ret_d     = StFr1;
          start_rmw = 1'b1;
        end else begin
          state_d = StFr1;
        end
      end
      StFr1: begin
        op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0, fh_q, slpe_pkg::LinkNil);
        fh_d      = slpe_pkg::to_link(e_q);
        ret_d     = StDone;
        start_rmw = 1'b1;
      end

      // Insert: store the key, then link it in.
      StIns0: begin
        op_d = slpe_pkg::mk_op(e_q, 1'b1, 1'b0, 1'b0, k_q,
                               slpe_pkg::LinkNil, slpe_pkg::LinkNil);
        ret_d     = StLk0;
        start_rmw = 1'b1;
      end

      // Unlink the entry from the current list.
      StUl0: begin
        ram_re    = 1'b1;
        ram_raddr = e_q;
        state_d   = StUl1;
      end
      StUl1: begin
        p_d = row_rd.prv;
        n_d = row_rd.nxt;
        if (!slpe_pkg::is_entry(row_rd.prv)) begin
          head_we    = 1'b1;
          head_wdata = row_rd.nxt;
          if (slpe_pkg::is_entry(row_rd.nxt)) begin
            op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(row_rd.nxt), 1'b0, 1'b0, 1'b1, '0,
                                   slpe_pkg::LinkNil, slpe_pkg::LinkNil);
            ret_d     = StUl2;
            start_rmw = 1'b1;
          end else begin
            state_d = StUl2;
          end
        end else begin
          op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(row_rd.prv), 1'b0, 1'b1, 1'b0, '0,
                                 row_rd.nxt, slpe_pkg::LinkNil);
          ret_d     = StUl1b;
          start_rmw = 1'b1;
        end
      end
      StUl1b: begin
        if (slpe_pkg::is_entry(n_q)) begin
          op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(n_q), 1'b0, 1'b0, 1'b1, '0,
                                 slpe_pkg::LinkNil, p_q);
          ret_d     = StUl2;
          start_rmw = 1'b1;
        end else begin
          state_d = StUl2;
        end
      end
      StUl2: begin
        op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0,
                               slpe_pkg::LinkNil, slpe_pkg::LinkNil);
        // A move continues with a sorted insert into the destination list.
        if (mv_q) begin
          lst_d = dst_q;
          ret_d = StLk0;
        end else begin
          ret_d = StDone;
        end
        start_rmw = 1'b1;
      end

      // Sorted link: fetch the entry's key, then the list head.
      StLk0: begin
        ram_re    = 1'b1;
        ram_raddr = e_q;
        state_d   = StLk1;
      end
      StLk1: begin
        k_d = row_rd.key;
        if (!slpe_pkg::is_entry(head_cur)) begin
          head_we    = 1'b1;
          head_wdata = slpe_pkg::to_link(e_q);
          op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0,
                                 slpe_pkg::LinkNil, slpe_pkg::LinkNil);
          ret_d     = StDone;
          start_rmw = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slpe_pkg::to_idx(head_cur);
          cur_d     = head_cur;
          state_d   = StLk2;
        end
      end
      StLk2: begin
        if (k_q < row_rd.key) begin
          // The new entry becomes the head of the list.
          head_we    = 1'b1;
          head_wdata = slpe_pkg::to_link(e_q);
          op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0, cur_q, slpe_pkg::LinkNil);
          ret_d     = StLk3;
          start_rmw = 1'b1;
        end else if (!slpe_pkg::is_entry(row_rd.nxt)) begin
          n_d     = row_rd.nxt;
          state_d = StInsA;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slpe_pkg::to_idx(row_rd.nxt);
          steps_d   = '0;
          state_d   = StWalk;
        end
      end
      StLk3: begin
        op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(cur_q), 1'b0, 1'b0, 1'b1, '0,
                               slpe_pkg::LinkNil, slpe_pkg::to_link(e_q));
        ret_d     = StDone;
        start_rmw = 1'b1;
      end

      // One link per cycle: the row just read is the successor of the current entry.
      StWalk: begin
        if (row_rd.key > k_q) begin
          n_d     = slpe_pkg::to_link(rd_addr_q);
          state_d = StInsA;
        end else begin
          cur_d   = slpe_pkg::to_link(rd_addr_q);
          steps_d = steps_q + slpe_pkg::LinkW'(1);
          if ((steps_q == slpe_pkg::LinkW'(slpe_pkg::PoolEntries - 1)) ||
              !slpe_pkg::is_entry(row_rd.nxt)) begin
            n_d     = row_rd.nxt;
            state_d = StInsA;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = slpe_pkg::to_idx(row_rd.nxt);
          end
        end
      end

      // Splice the entry in between the current entry and its successor.
      StInsA: begin
        op_d = slpe_pkg::mk_op(e_q, 1'b0, 1'b1, 1'b1, '0, n_q, cur_q);
        ret_d     = StInsB;
        start_rmw = 1'b1;
      end
      StInsB: begin
        if (slpe_pkg::is_entry(n_q)) begin
          op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(n_q), 1'b0, 1'b0, 1'b1, '0,
                                 slpe_pkg::LinkNil, slpe_pkg::to_link(e_q));
          ret_d     = StInsC;
          start_rmw = 1'b1;
        end else begin
          state_d = StInsC;
        end
      end
      StInsC: begin
        op_d = slpe_pkg::mk_op(slpe_pkg::to_idx(cur_q), 1'b0, 1'b1, 1'b0, '0,
                               slpe_pkg::to_link(e_q), slpe_pkg::LinkNil);
        ret_d     = StDone;
        start_rmw = 1'b1;
      end

      // Hand the result to the output register once it is free.
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase

    // Every row update starts by reading the row it modifies.
    if (start_rmw) begin
      ram_re    = 1'b1;
      ram_raddr = op_d.addr;
      state_d   = StRmwWr;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_idx_d   = res_idx_q;
      out_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      out_valid_q <= 1'b0;
      fh_q        <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      for (int i = 0; i < slpe_pkg::NumLists; i++) begin
        head_q[i] <= slpe_pkg::LinkNil;
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      fh_q        <= fh_d;
      if (head_we) begin
        head_q[lst_q] <= head_wdata;
      end
      if (ram_we) begin
        valid_q[op_q.addr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    e_q       <= e_d;
    k_q       <= k_d;
    lst_q     <= lst_d;
    dst_q     <= dst_d;
    mv_q      <= mv_d;
    cur_q     <= cur_d;
    n_q       <= n_d;
    p_q       <= p_d;
    steps_q   <= steps_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
    end
  end

  // A row is never read in the cycle it is written, so no forwarding is needed.
  `SLPE_ASSERT_IMP(a_no_rd_wr_overlap, ram_we, !ram_re, "row memory read and written together")
  // The search gives up after one pass over the pool.
  `SLPE_ASSERT_IMP(a_walk_bound, state_q == StWalk, steps_q < slpe_pkg::LinkNil, "walk overran")
  // The free head is always an entry or null.
  `SLPE_ASSERT_IMP(a_free_head_ok, 1'b1, fh_q <= slpe_pkg::LinkNil, "free head out of range")
  // One request at a time: the engine is busy in the cycle after it takes one.
  `SLPE_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "double accept")

endmodule
